/* rtl/core/qpe_pkg.sv */
// Shared types, character codes and helpers for the quoted-printable encoder.
package qpe_pkg;

  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOT    = 8'd46;
  localparam logic [7:0] CH_EQUALS = 8'd61;
  localparam logic [7:0] CH_TILDE  = 8'd126;
  localparam logic [7:0] CH_TWO    = 8'd50;
  localparam logic [7:0] CH_E      = 8'd69;

  localparam logic [6:0] LIMIT_RESET = 7'd76;
  localparam logic [6:0] COUNT_MAX   = 7'd127;

  // pieces one input byte can produce: held space, held CR, the byte itself
  localparam int unsigned QPE_OPS    = 3;
  localparam int unsigned QPE_QDEPTH = 2;
  localparam int unsigned QPE_PTR_W  = (QPE_QDEPTH > 1) ? $clog2(QPE_QDEPTH) : 1;
  localparam int unsigned QPE_CNT_W  = $clog2(QPE_QDEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       message_end;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_LIT,
    OP_HEX,
    OP_LF
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    op_t [QPE_OPS-1:0] ops;
    logic [1:0]        nops;
    logic              fin;
  } entry_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
  endfunction

endpackage

/* rtl/core/qpe_front.sv */
// Front end: takes input words, tracks held space/CR and queues encoding pieces.
module qpe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qpe_pkg::in_word_t in_word_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output qpe_pkg::entry_t   q_entry_o
);
  import qpe_pkg::*;

  logic       space_held_q, space_held_d;
  logic       cr_held_q, cr_held_d;
  logic       accept;
  logic [7:0] b;
  logic       fin;
  logic       is_lf, is_cr;
  logic       enc_hold;
  op_t        enc_op;
  entry_t     ent;

  assign b     = in_word_i.in_byte;
  assign fin   = in_word_i.final_byte;
  assign is_lf = (b == CH_LF);
  assign is_cr = (b == CH_CR);

  // plain encoding of the new byte when nothing is held in front of it
  always_comb begin
    enc_hold = 1'b0;
    enc_op   = '{kind: OP_LIT, data: b};
    if (is_lf) begin
      enc_op.kind = OP_LF;
    end else if (b == CH_SPACE) begin
      enc_op.kind = OP_HEX;
      enc_hold    = !fin;
    end else if (b == CH_EQUALS || b < CH_SPACE || b > CH_TILDE) begin
      enc_op.kind = OP_HEX;
    end
  end

  always_comb begin
    ent          = '0;
    ent.fin      = fin;
    space_held_d = space_held_q;
    cr_held_d    = cr_held_q;
    if (space_held_q && cr_held_q) begin
      ent.ops[0] = '{kind: (is_lf ? OP_HEX : OP_LIT), data: CH_SPACE};
      ent.ops[1] = '{kind: OP_HEX, data: CH_CR};
      ent.ops[2] = enc_op;
      ent.nops   = enc_hold ? 2'd2 : 2'd3;
      space_held_d = enc_hold;
      cr_held_d    = 1'b0;
    end else if (space_held_q) begin
      if (is_lf) begin
        ent.ops[0]   = '{kind: OP_HEX, data: CH_SPACE};
        ent.ops[1]   = enc_op;
        ent.nops     = 2'd2;
        space_held_d = 1'b0;
      end else if (is_cr && !fin) begin
        ent.nops  = 2'd0;
        cr_held_d = 1'b1;
      end else begin
        ent.ops[0]   = '{kind: OP_LIT, data: CH_SPACE};
        ent.ops[1]   = enc_op;
        ent.nops     = enc_hold ? 2'd1 : 2'd2;
        space_held_d = enc_hold;
      end
    end else begin
      ent.ops[0]   = enc_op;
      ent.nops     = enc_hold ? 2'd0 : 2'd1;
      space_held_d = enc_hold;
      cr_held_d    = 1'b0;
    end
    if (fin) begin
      space_held_d = 1'b0;
      cr_held_d    = 1'b0;
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && (ent.nops != 2'd0);
  assign q_entry_o  = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_held_q <= 1'b0;
      cr_held_q    <= 1'b0;
    end else if (accept) begin
      space_held_q <= space_held_d;
      cr_held_q    <= cr_held_d;
    end
  end

endmodule

/* rtl/core/qpe_fifo.sv */
// Short queue of piece lists between front and back end.
module qpe_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qpe_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output qpe_pkg::entry_t head_entry_o
);
  import qpe_pkg::*;

  entry_t               mem_q [QPE_QDEPTH];
  logic [QPE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPE_CNT_W-1:0] cnt_q;
  logic                 do_push, do_pop;

  localparam logic [QPE_PTR_W-1:0] PtrLast = QPE_PTR_W'(QPE_QDEPTH - 1);
  localparam logic [QPE_CNT_W-1:0] CntFull = QPE_CNT_W'(QPE_QDEPTH);

  assign full_o       = (cnt_q == CntFull);
  assign head_valid_o = (cnt_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/qpe_back.sv */
// Back end: expands queued pieces into output characters, one per cycle while the receiver is ready.
module qpe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [6:0]         line_limit_i,
  input  logic               head_valid_i,
  input  qpe_pkg::entry_t    head_entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qpe_pkg::out_word_t out_word_o
);
  import qpe_pkg::*;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_SB_CR = 3'd1;
  localparam logic [2:0] PH_SB_LF = 3'd2;
  localparam logic [2:0] PH_CHAR0 = 3'd3;
  localparam logic [2:0] PH_CHAR1 = 3'd4;
  localparam logic [2:0] PH_CHAR2 = 3'd5;

  logic [2:0] phase_q, phase_d;
  logic [1:0] op_idx_q, op_idx_d;
  logic [6:0] count_q, count_d;
  logic       out_valid_q;
  out_word_t  out_word_q;

  op_t        op;
  logic       is_lit, is_hex, is_lf;
  logic [7:0] need_sum, c0_sum;
  logic       soft_brk, dot_coded, wide;
  logic [7:0] c0_ch;
  logic [6:0] c0_cnt;
  logic [7:0] ch;
  logic       piece_last, entry_last, emit;

  assign op     = head_entry_i.ops[op_idx_q];
  assign is_lit = (op.kind == OP_LIT);
  assign is_hex = (op.kind == OP_HEX);
  assign is_lf  = (op.kind == OP_LF);

  assign need_sum  = {1'b0, count_q} + (is_lit ? 8'd1 : 8'd3);
  assign soft_brk  = !is_lf && (need_sum >= {1'b0, line_limit_i});
  assign dot_coded = is_lit && (op.data == CH_DOT) && (count_q == 7'd0);
  assign wide      = is_hex || dot_coded;
  assign c0_sum    = {1'b0, count_q} + (wide ? 8'd3 : 8'd1);
  assign c0_ch     = wide ? CH_EQUALS : op.data;
  assign c0_cnt    = c0_sum[7] ? COUNT_MAX : c0_sum[6:0];

  assign emit = head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    ch         = c0_ch;
    piece_last = 1'b0;
    unique case (phase_q)
      PH_START: begin
        if (is_lf) begin
          ch         = CH_LF;
          count_d    = 7'd0;
          piece_last = 1'b1;
        end else if (soft_brk) begin
          ch      = CH_EQUALS;
          phase_d = PH_SB_CR;
        end else begin
          count_d    = c0_cnt;
          phase_d    = PH_CHAR1;
          piece_last = !wide;
        end
      end
      PH_SB_CR: begin
        ch      = CH_CR;
        phase_d = PH_SB_LF;
      end
      PH_SB_LF: begin
        ch      = CH_LF;
        count_d = 7'd0;
        phase_d = PH_CHAR0;
      end
      PH_CHAR0: begin
        count_d    = c0_cnt;
        phase_d    = PH_CHAR1;
        piece_last = !wide;
      end
      PH_CHAR1: begin
        // not hex here means an escaped leading dot
        ch      = is_hex ? hex_char(op.data[7:4]) : CH_TWO;
        phase_d = PH_CHAR2;
      end
      PH_CHAR2: begin
        ch         = is_hex ? hex_char(op.data[3:0]) : CH_E;
        piece_last = 1'b1;
      end
      default: begin
        phase_d = PH_START;
      end
    endcase

    entry_last = piece_last && (op_idx_q == head_entry_i.nops - 2'd1);
    op_idx_d   = op_idx_q;
    if (piece_last) begin
      phase_d  = PH_START;
      op_idx_d = entry_last ? 2'd0 : op_idx_q + 2'd1;
    end
    if (entry_last && head_entry_i.fin) begin
      count_d = 7'd0;
    end
  end

  assign pop_o = emit && entry_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      op_idx_q    <= 2'd0;
      count_q     <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        phase_q     <= phase_d;
        op_idx_q    <= op_idx_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q <= '{out_byte: ch, run_end: entry_last,
                      message_end: entry_last && head_entry_i.fin};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* rtl/core/quoted_printable_encoder_top.sv */
// Quoted-printable encoder top level: front end, piece queue, back end, limit register.
//
// Input channel (in_valid_i/in_ready_o/in_word_i): one message byte per word,
// final_byte set on the last byte of a message. Output channel
// (out_valid_o/out_ready_i/out_word_o): one encoded character per word;
// run_end marks the last character caused by an input byte, message_end the
// last character of the message. A held space (or space plus CR) yields no
// output until the next byte decides how it is written.
// cfg_we_i/cfg_wdata_i write line_limit; write it only while idle.
// With the queue empty, an accepted byte is written into the piece queue and
// its first character is then registered into the output word.
// Throughput: the back end sends one character per cycle while the receiver
// is ready; a byte produces 1 to 18 characters (typically 1 or 3), and a byte
// that is only held produces none. A two-entry piece queue lets the front
// end keep accepting while the back end works or the receiver stalls.
// When out_ready_i is low the output word holds and the queue fills, then
// in_ready_o drops. Reset sets line_limit to 76 and clears line count, held
// flags, queue and output valid.
module quoted_printable_encoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qpe_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qpe_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_wdata_i
);
  import qpe_pkg::*;

  logic [6:0] line_limit_q;
  logic       q_full, q_push, q_pop, head_valid;
  entry_t     q_entry, head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      line_limit_q <= cfg_wdata_i;
    end
  end

  qpe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_word_i (in_word_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_entry)
  );

  qpe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_entry_i(q_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_valid_o(head_valid),
    .head_entry_o(head_entry)
  );

  qpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .line_limit_i(line_limit_q),
    .head_valid_i(head_valid),
    .head_entry_i(head_entry),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* rtl/core/qpe_checker.sv */
// Port-level checks for the quoted-printable encoder, bound to the top level.
module qpe_port_props (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input qpe_pkg::out_word_t out_word_o
);
  import qpe_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_msg_end_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.message_end |-> out_word_o.run_end)
    else $error("message_end without run_end");

  // '=' always opens an escape or a soft break, never ends a run
  a_eq_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.out_byte == CH_EQUALS |-> !out_word_o.run_end)
    else $error("run ended on '='");

  // a raw CR only appears inside a soft break, followed by LF
  a_cr_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.out_byte == CH_CR |-> !out_word_o.run_end)
    else $error("run ended on CR");

endmodule

bind quoted_printable_encoder_top qpe_port_props u_qpe_port_props (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_word_o (out_word_o)
);

/* dv/qpe_checker.sv */
// Checker for the quoted-printable encoder: predicts encoded characters and compares them.
module qpe_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  qpe_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  qpe_pkg::out_word_t out_word_i,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_wdata_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);
  import qpe_pkg::*;

  localparam int unsigned MAX_CHARS = 18;

  logic [6:0] limit_q;
  logic [6:0] line_cnt;
  bit         space_wait;
  bit         cr_wait;
  logic [7:0] step_chars[$];
  out_word_t  expected_chars[$];

  function automatic logic [7:0] nibble_char(logic [3:0] n);
    return (n < 4'd10) ? 8'd48 + n : 8'd55 + n;
  endfunction

  function automatic void put_char(logic [7:0] c);
    if (step_chars.size() < MAX_CHARS) step_chars.push_back(c);
  endfunction

  function automatic void bump_count(int n);
    int t;
    t = int'(line_cnt) + n;
    line_cnt = (t > int'(COUNT_MAX)) ? COUNT_MAX : 7'(t);
  endfunction

  // soft break when the next piece would bring the line to the limit
  function automatic void maybe_break(int w);
    if (int'(line_cnt) + w >= int'(limit_q)) begin
      put_char(CH_EQUALS);
      put_char(CH_CR);
      put_char(CH_LF);
      line_cnt = '0;
    end
  endfunction

  function automatic void put_literal(logic [7:0] c);
    maybe_break(1);
    put_char(c);
    bump_count(1);
  endfunction

  function automatic void put_escaped(logic [7:0] c);
    maybe_break(3);
    put_char(CH_EQUALS);
    put_char(nibble_char(c[7:4]));
    put_char(nibble_char(c[3:0]));
    bump_count(3);
  endfunction

  // encode a byte with nothing held
  function automatic void encode_fresh(logic [7:0] b, logic fin);
    if (b == CH_LF) begin
      put_char(CH_LF);
      line_cnt = '0;
    end else if (b == CH_SPACE) begin
      if (fin) put_escaped(CH_SPACE);
      else space_wait = 1'b1;
    end else if (b == CH_EQUALS || b < CH_SPACE || b > CH_TILDE) begin
      put_escaped(b);
    end else begin
      // a dot opening a line is escaped, but the break check uses width one
      maybe_break(1);
      if (b == CH_DOT && line_cnt == '0) begin
        put_char(CH_EQUALS);
        put_char(nibble_char(CH_DOT[7:4]));
        put_char(nibble_char(CH_DOT[3:0]));
        bump_count(3);
      end else begin
        put_char(b);
        bump_count(1);
      end
    end
  endfunction

  function automatic void encode_word(in_word_t w);
    out_word_t e;
    step_chars.delete();
    if (space_wait && cr_wait) begin
      if (w.in_byte == CH_LF) put_escaped(CH_SPACE);
      else put_literal(CH_SPACE);
      put_escaped(CH_CR);
      space_wait = 1'b0;
      cr_wait    = 1'b0;
      encode_fresh(w.in_byte, w.final_byte);
    end else if (space_wait) begin
      if (w.in_byte == CH_LF) begin
        put_escaped(CH_SPACE);
        space_wait = 1'b0;
        encode_fresh(w.in_byte, w.final_byte);
      end else if (w.in_byte == CH_CR && !w.final_byte) begin
        cr_wait = 1'b1;
      end else begin
        put_literal(CH_SPACE);
        space_wait = 1'b0;
        encode_fresh(w.in_byte, w.final_byte);
      end
    end else begin
      cr_wait = 1'b0;
      encode_fresh(w.in_byte, w.final_byte);
    end
    if (w.final_byte) begin
      line_cnt   = '0;
      space_wait = 1'b0;
      cr_wait    = 1'b0;
    end
    foreach (step_chars[k]) begin
      e.out_byte    = step_chars[k];
      e.run_end     = (k == step_chars.size() - 1);
      e.message_end = e.run_end && w.final_byte;
      expected_chars.push_back(e);
    end
  endfunction

  task automatic report_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    fail_count_o++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      limit_q      = LIMIT_RESET;
      line_cnt     = '0;
      space_wait   = 1'b0;
      cr_wait      = 1'b0;
      fail_count_o = 0;
      expected_chars.delete();
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) encode_word(in_word_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected word, expected none, actual %h run_end %0b message_end %0b",
                   $time, out_word_i.out_byte, out_word_i.run_end, out_word_i.message_end);
        end else begin
          e = expected_chars.pop_front();
          if (out_word_i.out_byte !== e.out_byte)
            report_field("out_byte", e.out_byte, out_word_i.out_byte);
          if (out_word_i.run_end !== e.run_end)
            report_field("run_end", 8'(e.run_end), 8'(out_word_i.run_end));
          if (out_word_i.message_end !== e.message_end)
            report_field("message_end", 8'(e.message_end), 8'(out_word_i.message_end));
        end
      end
    end
    pending_o = expected_chars.size();
  end

endmodule

/* dv/tb_quoted_printable_encoder_top.sv */
// Testbench top for the quoted-printable encoder: clock, reset, stimulus and verdict.
module tb_quoted_printable_encoder_top;
  import qpe_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned TAIL_TICKS   = 20;
  localparam int unsigned PHASE_ITEMS  = 62;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_word_t    in_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_word_t   out_word_o;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned sent_count;
  int unsigned idle_cycles;
  bit          steady;

  quoted_printable_encoder_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  qpe_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_i   (out_word_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: short stalls, some long ones, and long stretches always ready
  initial begin
    int unsigned r;
    int unsigned n;
    logic        v;
    wait (rst_ni === 1'b1);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        v = 1'b0;
        n = $urandom_range(1, 3);
      end else if (r < 20) begin
        v = 1'b0;
        n = $urandom_range(5, 30);
      end else if (r < 30) begin
        v = 1'b1;
        n = $urandom_range(40, 120);
      end else begin
        v = 1'b1;
        n = $urandom_range(1, 6);
      end
      @(negedge clk_i);
      out_ready_i <= v;
      repeat (n - 1) @(negedge clk_i);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_byte(logic [7:0] b, logic fin);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{in_byte: b, final_byte: fin};
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
  endtask

  // stop sending and wait until every expected word is out
  task automatic drain(int unsigned tail);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (tail) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [6:0] v);
    drain(SETTLE_TICKS);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // one message built from tokens that hit the held space / CR paths often
  task automatic send_message(int unsigned budget);
    logic [7:0]  msg[$];
    int unsigned len;
    int unsigned r;
    bit          long_line;
    long_line = ($urandom_range(0, 9) == 0);
    len = long_line ? $urandom_range(80, 160) : $urandom_range(1, 24);
    // keep the phase close to its byte count
    if (len > budget) len = budget;
    steady = ($urandom_range(0, 3) == 0);
    while (msg.size() < len) begin
      r = $urandom_range(0, 99);
      if (long_line && r >= 47 && r < 90) r = $urandom_range(0, 46);
      if (r < 35)      msg.push_back(8'($urandom_range(33, 126)));
      else if (r < 47) msg.push_back(CH_SPACE);
      else if (r < 53) begin
        msg.push_back(CH_SPACE); msg.push_back(CH_CR); msg.push_back(CH_LF);
      end else if (r < 58) begin
        msg.push_back(CH_SPACE); msg.push_back(CH_CR);
      end else if (r < 63) begin
        msg.push_back(CH_SPACE); msg.push_back(CH_LF);
      end else if (r < 70) begin
        msg.push_back(CH_CR); msg.push_back(CH_LF);
      end else if (r < 76) msg.push_back(CH_LF);
      else if (r < 81)     msg.push_back(CH_DOT);
      else if (r < 85)     msg.push_back(CH_EQUALS);
      else if (r < 90) begin
        msg.push_back(CH_LF); msg.push_back(CH_DOT);
      end else msg.push_back(8'($urandom_range(0, 255)));
    end
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic run_phase(logic [6:0] lim);
    int unsigned phase_end;
    write_limit(lim);
    phase_end = sent_count + PHASE_ITEMS;
    while (sent_count < phase_end) send_message(phase_end - sent_count);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    sent_count  = 0;
    idle_cycles = 0;
    steady      = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: escapes, extremes, dot at line start, held space and CR cases
    send_byte(CH_DOT, 1'b0);
    send_byte(CH_EQUALS, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_TILDE, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_CR, 1'b1);
    send_byte(CH_SPACE, 1'b1);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(8'h62, 1'b1);

    run_phase(7'd8);
    run_phase(7'd127);
    run_phase(LIMIT_RESET);
    run_phase(7'($urandom_range(8, 127)));
    run_phase(7'd20);
    run_phase(7'd8);
    run_phase(7'($urandom_range(8, 127)));

    drain(TAIL_TICKS);
    if (fail_count == 0 && pending == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
